// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the radix text converter. Each macro samples on
// clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ITRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true outside reset.
`define ITRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ITRT_ASSERT(lbl, prop, msg)
`define ITRT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and helper functions of the radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // Default parameter values.
  localparam int unsigned MAX_RADIX_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Dividend bits retired by the divider in one cycle.
  localparam int unsigned STEP_BITS = 8;

  // Fixed field widths.
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned SYM_W   = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 64;

  // Constants.
  localparam logic [CHAR_W-1:0]  MINUS_CHAR         = 8'h2D;
  localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
  localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

  // Register indexes, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_RADIX,
    REG_SYM_LOW,
    REG_SYM_HIGH
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp the programmed radix into the range 2 to max_r.
  function automatic logic [RADIX_W-1:0] clamp_radix(
    input logic [RADIX_W-1:0] r,
    input logic [RADIX_W-1:0] max_r
  );
    logic [RADIX_W-1:0] res;
    res = r;
    if (res < RADIX_W'(2)) res = RADIX_W'(2);
    if (res > max_r) res = max_r;
    return res;
  endfunction

  // Look up the character of a digit value in the alphabet.
  function automatic logic [CHAR_W-1:0] symbol_of(
    input logic [3:0]       d,
    input logic [SYM_W-1:0] lo,
    input logic [SYM_W-1:0] hi
  );
    logic [CHAR_W-1:0] res;
    if (d[3]) res = hi[{d[2:0], 3'b000} +: CHAR_W];
    else      res = lo[{d[2:0], 3'b000} +: CHAR_W];
    return res;
  endfunction

endpackage

// File: sv/itrt_regs.sv
// ----------------------------------------------------------------------------
// itrt_regs
// Configuration register file: radix and the two halves of the digit
// alphabet, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module itrt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itrt_pkg::ADDR_W-1:0]   paddr,
  input  logic [itrt_pkg::DATA_W-1:0]   pwdata,
  output logic [itrt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [itrt_pkg::RADIX_W-1:0]  radix_o,
  output logic [itrt_pkg::SYM_W-1:0]    symbols_low_o,
  output logic [itrt_pkg::SYM_W-1:0]    symbols_high_o
);
  import itrt_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [SYM_W-1:0]   sym_low_q;
  logic [SYM_W-1:0]   sym_high_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:3]);

  // Register writes; an index with no register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      sym_low_q  <= SYMBOLS_LOW_RESET;
      sym_high_q <= SYMBOLS_HIGH_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_RADIX:    radix_q    <= pwdata[RADIX_W-1:0];
        REG_SYM_LOW:  sym_low_q  <= pwdata;
        REG_SYM_HIGH: sym_high_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      REG_RADIX:    prdata = DATA_W'(radix_q);
      REG_SYM_LOW:  prdata = sym_low_q;
      REG_SYM_HIGH: prdata = sym_high_q;
      default:      prdata = '0;
    endcase
  end

  assign radix_o        = radix_q;
  assign symbols_low_o  = sym_low_q;
  assign symbols_high_o = sym_high_q;

endmodule

// File: sv/itrt_div.sv
// ----------------------------------------------------------------------------
// itrt_div
// Iterative divider by a small radix. Retires STEP_BITS dividend bits per
// cycle with restoring compare and subtract, giving quotient and remainder.
// ----------------------------------------------------------------------------
module itrt_div #(
  parameter int unsigned VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         dividend_i,
  input  logic [itrt_pkg::RADIX_W-1:0]  radix_i,
  output itrt_pkg::div_stat_t           stat_o,
  output logic [VALUE_BITS-1:0]         quot_o,
  output logic [itrt_pkg::RADIX_W-1:0]  rem_o
);
  import itrt_pkg::*;

  localparam int unsigned DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W      = DIV_CYCLES * STEP_BITS;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES + 1);

  logic [PAD_W-1:0]   sh_q, sh_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [STEP_BITS-1:0] qbits;

  // One cycle of restoring division over the top STEP_BITS bits.
  always_comb begin
    logic [RADIX_W-1:0] r;
    r = rem_q;
    qbits = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      r = {r[RADIX_W-2:0], sh_q[PAD_W-1-j]};
      if (r >= radix_i) begin
        r = r - radix_i;
        qbits[STEP_BITS-1-j] = 1'b1;
      end
    end
    rem_d = r;
    sh_d  = (sh_q << STEP_BITS) | PAD_W'(qbits);
  end

  // Control: count the steps of one division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the shift register ends up holding the quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PAD_W'(dividend_i);
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = sh_q[VALUE_BITS-1:0];
  assign rem_o       = rem_q;

endmodule

// File: sv/integer_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Converts a signed integer into its text in a programmable radix and
// alphabet, one character per output request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one signed number per request (in_valid_i,
//   in_stall_o). The output channel gives one character per request with
//   final_char_o set on the last character of the number's text. A negative
//   number starts with a minus sign; digits follow most significant first.
//   Users write radix and alphabet over the APB port while the block idles.
//   The block itself does not enforce this.
// Timing:
//   Digits are produced least significant first by an iterative divider that
//   retires 8 dividend bits per cycle; one division per digit, then one
//   character per cycle, a minus sign first, while the output does not stall.
//   The input is stalled from acceptance until the last character has been
//   loaded into the output register, which then waits alone for the receiver.
// Reset:
//   Registers return to radix 10 and the alphabet "0123456789"; the output
//   register is emptied. No clearing pass is needed.
// Stall:
//   While out_stall_i is high a full output register keeps its character and
//   the sequencer waits to load more; no character is dropped or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_radix_text_top #(
  parameter int unsigned MAX_RADIX  = itrt_pkg::MAX_RADIX_DEF,
  parameter int unsigned VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_BITS-1:0]  number_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itrt_pkg::CHAR_W-1:0]   text_char_o,
  output logic                          final_char_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itrt_pkg::ADDR_W-1:0]   paddr,
  input  logic [itrt_pkg::DATA_W-1:0]   pwdata,
  output logic [itrt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import itrt_pkg::*;

  localparam int unsigned DIGIT_W = $clog2(MAX_RADIX);
  localparam int unsigned CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W   = $clog2(VALUE_BITS);
  localparam logic [RADIX_W-1:0] MAX_R = RADIX_W'(MAX_RADIX);

  // Configuration registers.
  logic [RADIX_W-1:0] radix_cfg;
  logic [SYM_W-1:0]   sym_low;
  logic [SYM_W-1:0]   sym_high;
  logic [RADIX_W-1:0] radix_eff;

  itrt_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .radix_o        (radix_cfg),
    .symbols_low_o  (sym_low),
    .symbols_high_o (sym_high)
  );

  assign radix_eff = clamp_radix(radix_cfg, MAX_R);

  // Sequencer and datapath state.
  state_e              state_q, state_d;
  logic                neg_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DIGIT_W-1:0]  digits_q [VALUE_BITS];
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_final_q;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [CHAR_W-1:0]   out_char;
  logic                out_final;
  logic                div_start;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] div_dividend;
  div_stat_t           div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]  div_rem;
  logic [CNT_W-1:0]    rd_cnt;
  logic                quot_zero;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign mag       = number_i[VALUE_BITS-1] ? (~number_i + VALUE_BITS'(1)) : number_i;
  assign div_dividend = (state_q == ST_IDLE) ? mag : div_quot;
  assign rd_cnt    = cnt_q - CNT_W'(1);
  assign quot_zero = (div_quot == '0);

  // Shared divider.
  itrt_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (radix_eff),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done && quot_zero) state_d = neg_q ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (cnt_q == CNT_W'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_char   = MINUS_CHAR;
    out_final  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i;
      end
      ST_DIVIDE: begin
        div_start = div_stat.done && !quot_zero;
      end
      ST_SIGN: begin
        out_load = out_free;
      end
      ST_EMIT: begin
        out_load  = out_free;
        out_char  = symbol_of(4'(digits_q[rd_cnt[IDX_W-1:0]]), sym_low, sym_high);
        out_final = (cnt_q == CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
        neg_q <= number_i[VALUE_BITS-1];
      end else if (div_stat.done && (state_q == ST_DIVIDE)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (out_load && (state_q == ST_EMIT)) begin
        cnt_q <= rd_cnt;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Digit store, written least significant digit first.
  always_ff @(posedge clk_i) begin
    if (div_stat.done && (state_q == ST_DIVIDE)) begin
      digits_q[cnt_q[IDX_W-1:0]] <= div_rem[DIGIT_W-1:0];
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q  <= out_char;
      out_final_q <= out_final;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_char_o  = out_char_q;
  assign final_char_o = out_final_q;

  // Checks on the sequencer.
  `ITRT_ASSERT(a_start_free, div_start |-> !div_stat.busy, "divider restarted while busy")
  `ITRT_ASSERT(a_done_in_div, div_stat.done |-> (state_q == ST_DIVIDE), "divider done outside divide")
  `ITRT_ASSERT(a_emit_cnt, (state_q == ST_EMIT) |-> (cnt_q != '0), "emitting with no digits left")
  `ITRT_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(VALUE_BITS), "digit count overflow")

endmodule
